/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on the rising clock edge
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every edge outside reset
`define PCS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PCS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/pcs_pkg.sv */
// ----------------------------------------------------------------------------
// pcs_pkg
// shared widths, types and constants of the palindromic subsequence counter
// ----------------------------------------------------------------------------
package pcs_pkg;

   localparam int PCS_MAX_LEN = 32;
   localparam int SYM_W       = 8;
   localparam int CNT_W       = 32;

   typedef logic [CNT_W-1:0] count_type;
   typedef logic [SYM_W-1:0] symbol_type;

   // control group for the shared arithmetic unit
   typedef struct packed {
      logic match;
      logic prev_unit;
      logic inner_unit;
      logic inner_zero;
   } alu_ctl_type;

endpackage

/* rtl/core/pcs_req_if.sv */
// ----------------------------------------------------------------------------
// pcs_req_if
// input channel: one symbol per beat, last closes the string
// ----------------------------------------------------------------------------
interface pcs_req_if;
   logic                    valid;
   logic                    ready;
   logic [pcs_pkg::SYM_W-1:0] symbol;
   logic                    last;

   modport source (output valid, output symbol, output last, input ready);
   modport sink   (input valid, input symbol, input last, output ready);
endinterface

/* rtl/core/pcs_rsp_if.sv */
// ----------------------------------------------------------------------------
// pcs_rsp_if
// result channel: one count per closed string
// ----------------------------------------------------------------------------
interface pcs_rsp_if;
   logic                    valid;
   logic                    ready;
   logic [pcs_pkg::CNT_W-1:0] count;
   logic                    too_long;

   modport source (output valid, output count, output too_long, input ready);
   modport sink   (input valid, input count, input too_long, output ready);
endinterface

/* rtl/core/pcs_text.sv */
// ----------------------------------------------------------------------------
// pcs_text
// symbol store: one write port, two registered read ports
// ----------------------------------------------------------------------------
module pcs_text #(
   parameter int MAX_LEN = pcs_pkg::PCS_MAX_LEN,
   parameter int LW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [LW-1:0]        wr_addr,
   input  pcs_pkg::symbol_type  wr_data,
   input  logic                 rd_en,
   input  logic [LW-1:0]        rd_addr_a,
   input  logic [LW-1:0]        rd_addr_b,
   output pcs_pkg::symbol_type  rd_data_a,
   output pcs_pkg::symbol_type  rd_data_b
);
   import pcs_pkg::*;

   symbol_type mem [0:MAX_LEN-1];
   symbol_type rd_a_ff;
   symbol_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* rtl/core/pcs_diag.sv */
// ----------------------------------------------------------------------------
// pcs_diag
// three rotating diagonal banks of interval counts, two registered read ports
// ----------------------------------------------------------------------------
module pcs_diag #(
   parameter int MAX_LEN = pcs_pkg::PCS_MAX_LEN,
   parameter int LW      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [LW+1:0]       wr_addr,
   input  pcs_pkg::count_type  wr_data,
   input  logic                rd_en,
   input  logic [LW+1:0]       rd_addr_a,
   input  logic [LW+1:0]       rd_addr_b,
   output pcs_pkg::count_type  rd_data_a,
   output pcs_pkg::count_type  rd_data_b
);
   import pcs_pkg::*;

   localparam int DEPTH = 3 * (2 ** LW);

   count_type mem [0:DEPTH-1];
   count_type rd_a_ff;
   count_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* rtl/core/pcs_alu.sv */
// ----------------------------------------------------------------------------
// pcs_alu
// shared cell update: outer sum plus one on matching ends, else minus inner
// ----------------------------------------------------------------------------
module pcs_alu (
   input  pcs_pkg::alu_ctl_type ctl,
   input  pcs_pkg::count_type   prev_raw,
   input  pcs_pkg::count_type   inner_raw,
   input  pcs_pkg::count_type   held,
   output pcs_pkg::count_type   prev_val,
   output pcs_pkg::count_type   result
);
   import pcs_pkg::*;

   count_type inner;
   count_type outer;
   count_type addend;

   always_comb begin
      prev_val = ctl.prev_unit ? count_type'(1) : prev_raw;
      priority if (ctl.inner_zero) begin
         inner = '0;
      end else if (ctl.inner_unit) begin
         inner = count_type'(1);
      end else begin
         inner = inner_raw;
      end
      outer  = prev_val + held;
      addend = ctl.match ? count_type'(1) : (~inner + count_type'(1));
      result = outer + addend;
   end

endmodule

/* rtl/core/palindromic_subsequence_counter_core.sv */
// sequence: after the closing beat each diagonal is primed, then each interval
// cell is read and then calculated, and the count is handed over from done
// throughput: cell updates run one at a time through the shared adder and the
// single diagonal store; symbols load one per cycle while idle
// reset: synchronous, clears the sequencer, length, overflow and result valid
// ----------------------------------------------------------------------------
// palindromic_subsequence_counter_core
// loads a string and counts its palindromic subsequences by interval table
// ----------------------------------------------------------------------------
module palindromic_subsequence_counter_core #(
   parameter int MAX_LEN = pcs_pkg::PCS_MAX_LEN
) (
   input  logic       clock,
   input  logic       reset,
   pcs_req_if.sink    req_bus,
   pcs_rsp_if.source  rsp_bus
);
   import pcs_pkg::*;

   localparam int LW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int LENW = $clog2(MAX_LEN + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PRIME = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_CALC  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam logic [1:0] BANK_0 = 2'd0;
   localparam logic [1:0] BANK_1 = 2'd1;
   localparam logic [1:0] BANK_2 = 2'd2;

   logic [2:0]      state_ff,    state_in;
   logic [LENW-1:0] length_ff,   length_in;
   logic            ovf_ff,      ovf_in;
   logic [LENW-1:0] n_ff,        n_in;
   logic            long_ff,     long_in;
   logic [LENW-1:0] span_ff,     span_in;
   logic [LW-1:0]   lo_ff,       lo_in;
   logic [1:0]      bank_ff,     bank_in;
   count_type       held_ff,     held_in;
   count_type       result_ff,   result_in;
   logic            rsp_vld_ff,  rsp_vld_in;
   count_type       rsp_cnt_ff,  rsp_cnt_in;
   logic            rsp_long_ff, rsp_long_in;

   logic            req_beat;
   logic            room;
   logic [1:0]      bank_prev;
   logic [1:0]      bank_prev2;
   logic [LENW-1:0] lo_ext;
   logic [LENW-1:0] lo_next;
   logic [LENW-1:0] hi;
   logic [LENW-1:0] rem;

   logic            text_wr;
   logic            text_rd;
   symbol_type      sym_a;
   symbol_type      sym_b;
   logic            diag_wr;
   logic            diag_rd;
   logic [LW+1:0]   diag_addr_a;
   logic [LW+1:0]   diag_addr_b;
   count_type       diag_a;
   count_type       diag_b;
   alu_ctl_type     alu_ctl;
   count_type       alu_prev;
   count_type       alu_result;

   assign req_bus.ready    = (state_ff == ST_IDLE);
   assign req_beat         = req_bus.valid && req_bus.ready;
   assign room             = (length_ff < LENW'(MAX_LEN));
   assign rsp_bus.valid    = rsp_vld_ff;
   assign rsp_bus.count    = rsp_cnt_ff;
   assign rsp_bus.too_long = rsp_long_ff;

   always_comb begin
      unique case (bank_ff)
         BANK_0:  begin bank_prev = BANK_2; bank_prev2 = BANK_1; end
         BANK_1:  begin bank_prev = BANK_0; bank_prev2 = BANK_2; end
         default: begin bank_prev = BANK_1; bank_prev2 = BANK_0; end
      endcase
   end

   assign lo_ext  = LENW'(lo_ff);
   assign lo_next = lo_ext + LENW'(1);
   assign hi      = lo_ext + span_ff - LENW'(1);
   assign rem     = n_ff - span_ff;

   assign text_wr     = req_beat && room;
   assign text_rd     = (state_ff == ST_READ);
   assign diag_rd     = (state_ff == ST_PRIME) || (state_ff == ST_READ);
   assign diag_wr     = (state_ff == ST_CALC);
   assign diag_addr_a = (state_ff == ST_PRIME) ? {bank_prev, LW'(0)}
                                               : {bank_prev, lo_next[LW-1:0]};
   assign diag_addr_b = {bank_prev2, lo_next[LW-1:0]};

   assign alu_ctl.match      = (sym_a == sym_b);
   assign alu_ctl.prev_unit  = (span_ff == LENW'(2));
   assign alu_ctl.inner_unit = (span_ff == LENW'(3));
   assign alu_ctl.inner_zero = (span_ff == LENW'(2));

   pcs_text #(.MAX_LEN(MAX_LEN), .LW(LW)) u_text (
      .clock     (clock),
      .wr_en     (text_wr),
      .wr_addr   (length_ff[LW-1:0]),
      .wr_data   (req_bus.symbol),
      .rd_en     (text_rd),
      .rd_addr_a (lo_ff),
      .rd_addr_b (hi[LW-1:0]),
      .rd_data_a (sym_a),
      .rd_data_b (sym_b)
   );

   pcs_diag #(.MAX_LEN(MAX_LEN), .LW(LW)) u_diag (
      .clock     (clock),
      .wr_en     (diag_wr),
      .wr_addr   ({bank_ff, lo_ff}),
      .wr_data   (alu_result),
      .rd_en     (diag_rd),
      .rd_addr_a (diag_addr_a),
      .rd_addr_b (diag_addr_b),
      .rd_data_a (diag_a),
      .rd_data_b (diag_b)
   );

   pcs_alu u_alu (
      .ctl       (alu_ctl),
      .prev_raw  (diag_a),
      .inner_raw (diag_b),
      .held      (held_ff),
      .prev_val  (alu_prev),
      .result    (alu_result)
   );

   always_comb begin
      state_in    = state_ff;
      length_in   = length_ff;
      ovf_in      = ovf_ff;
      n_in        = n_ff;
      long_in     = long_ff;
      span_in     = span_ff;
      lo_in       = lo_ff;
      bank_in     = bank_ff;
      held_in     = held_ff;
      result_in   = result_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_cnt_in  = rsp_cnt_ff;
      rsp_long_in = rsp_long_ff;

      if (rsp_bus.valid && rsp_bus.ready) begin
         rsp_vld_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               if (room) begin
                  length_in = length_ff + LENW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_bus.last) begin
                  n_in      = room ? (length_ff + LENW'(1)) : length_ff;
                  long_in   = ovf_ff || !room;
                  length_in = '0;
                  ovf_in    = 1'b0;
                  span_in   = LENW'(2);
                  bank_in   = BANK_2;
                  result_in = count_type'(1);
                  state_in  = (n_in == LENW'(1)) ? ST_DONE : ST_PRIME;
               end
            end
         end
         ST_PRIME: begin
            lo_in    = '0;
            state_in = ST_READ;
         end
         ST_READ: begin
            if (lo_ff == '0) begin
               held_in = alu_ctl.prev_unit ? count_type'(1) : diag_a;
            end
            state_in = ST_CALC;
         end
         ST_CALC: begin
            held_in = alu_prev;
            if (lo_ext == rem) begin
               if (span_ff == n_ff) begin
                  result_in = alu_result;
                  state_in  = ST_DONE;
               end else begin
                  span_in  = span_ff + LENW'(1);
                  bank_in  = (bank_ff == BANK_2) ? BANK_0 : (bank_ff + 2'd1);
                  state_in = ST_PRIME;
               end
            end else begin
               lo_in    = lo_next[LW-1:0];
               state_in = ST_READ;
            end
         end
         ST_DONE: begin
            if (!rsp_vld_ff || rsp_bus.ready) begin
               rsp_vld_in  = 1'b1;
               rsp_cnt_in  = result_ff;
               rsp_long_in = long_ff;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         length_ff  <= '0;
         ovf_ff     <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         length_ff  <= length_in;
         ovf_ff     <= ovf_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      long_ff     <= long_in;
      span_ff     <= span_in;
      lo_ff       <= lo_in;
      bank_ff     <= bank_in;
      held_ff     <= held_in;
      result_ff   <= result_in;
      rsp_cnt_ff  <= rsp_cnt_in;
      rsp_long_ff <= rsp_long_in;
   end

   `include "assert_macros.svh"

   `PCS_ASSERT_NEXT(a_close_leaves_idle, req_beat && req_bus.last, state_ff != ST_IDLE, "closing beat did not start the fill")
   `PCS_ASSERT(a_span_bounds, ((state_ff == ST_READ) || (state_ff == ST_CALC)) |-> ((span_ff >= LENW'(2)) && (span_ff <= n_ff)), "span outside string length")
   `PCS_ASSERT(a_lo_bounds, ((state_ff == ST_READ) || (state_ff == ST_CALC)) |-> (lo_ext <= rem), "cell start beyond diagonal end")
   `PCS_ASSERT(a_rsp_from_done, $rose(rsp_vld_ff) |-> ($past(state_ff) == ST_DONE), "result raised outside hand-over")

endmodule

/* tb/palindromic_subsequence_counter_core_tb.sv */
// ----------------------------------------------------------------------------
// palindromic_subsequence_counter_core_tb
// drives strings of symbols into the counter and checks each closing count
// against a local interval-table count, with random idling on both channels
// ----------------------------------------------------------------------------
module palindromic_subsequence_counter_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pcs_pkg::*;

   localparam int  CYCLE_LIMIT = 1_000_000;
   localparam int  CALM_TAIL   = 60;
   localparam int  DRAIN_WAIT  = PCS_MAX_LEN * PCS_MAX_LEN + 64;

   typedef struct packed {
      symbol_type symbol;
      logic       last;
   } symbol_beat_type;

   typedef struct packed {
      count_type count;
      logic      too_long;
   } count_result_type;

   logic clock;
   logic reset;

   pcs_req_if req_bus ();
   pcs_rsp_if rsp_bus ();

   palindromic_subsequence_counter_core u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   symbol_beat_type  symbol_queue[$];
   count_result_type count_queue[$];

   symbol_type text_copy [PCS_MAX_LEN];
   int         held_len;
   logic       spilled;
   int         gap;
   int         stall;
   int         errors;
   int         cycles;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic count_type count_palindromes(input symbol_type s [PCS_MAX_LEN],
                                                   input int n);
      count_type tbl [PCS_MAX_LEN][PCS_MAX_LEN];
      count_type outer;
      count_type inner;
      int        span;
      int        lo;
      int        hi;
      for (lo = 0; lo < n; lo++) tbl[lo][lo] = 1;
      for (span = 2; span <= n; span++) begin
         for (lo = 0; lo + span <= n; lo++) begin
            hi    = lo + span - 1;
            outer = tbl[lo+1][hi] + tbl[lo][hi-1];
            if (s[lo] == s[hi]) begin
               tbl[lo][hi] = outer + 1;
            end else begin
               inner       = (span == 2) ? count_type'(0) : tbl[lo+1][hi-1];
               tbl[lo][hi] = outer - inner;
            end
         end
      end
      return tbl[0][n-1];
   endfunction

   task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                  input logic [CNT_W-1:0] want);
      $display("mismatch %s: got %h, expected %h at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   // spread 1 repeats base, spread 256 is fully random, otherwise a small alphabet
   task automatic queue_string(input int len, input int spread, input symbol_type base);
      symbol_beat_type b;
      for (int k = 0; k < len; k++) begin
         b.symbol = (spread >= 256) ? symbol_type'($urandom)
                                    : base ^ symbol_type'($urandom_range(0, spread - 1));
         b.last   = (k == len - 1);
         symbol_queue.push_back(b);
      end
   endtask

   task automatic queue_pair(input symbol_type a, input symbol_type b, input logic closes);
      symbol_queue.push_back('{symbol: a, last: 1'b0});
      symbol_queue.push_back('{symbol: b, last: closes});
   endtask

   // driver with prediction on each accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         gap           <= 0;
         held_len      = 0;
         spilled       = 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            if (held_len < PCS_MAX_LEN) begin
               text_copy[held_len] = req_bus.symbol;
               held_len++;
            end else begin
               spilled = 1'b1;
            end
            if (req_bus.last) begin
               count_queue.push_back('{count: count_palindromes(text_copy, held_len),
                                       too_long: spilled});
               held_len = 0;
               spilled  = 1'b0;
            end
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (symbol_queue.size() >= CALM_TAIL && gap > 0) begin
               gap           <= gap - 1;
               req_bus.valid <= 1'b0;
            end else if (symbol_queue.size() == 0) begin
               req_bus.valid <= 1'b0;
            end else if (symbol_queue.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
               gap           <= $urandom_range(0, 4);
               req_bus.valid <= 1'b0;
            end else begin
               req_bus.valid  <= 1'b1;
               req_bus.symbol <= symbol_queue[0].symbol;
               req_bus.last   <= symbol_queue[0].last;
               void'(symbol_queue.pop_front());
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      count_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall         <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (count_queue.size() == 0) begin
               report_mismatch("unexpected count beat", rsp_bus.count, '0);
            end else begin
               want = count_queue.pop_front();
               if (rsp_bus.count !== want.count)
                  report_mismatch("count", rsp_bus.count, want.count);
               if (rsp_bus.too_long !== want.too_long)
                  report_mismatch("too_long", CNT_W'(rsp_bus.too_long), CNT_W'(want.too_long));
            end
         end
         if (symbol_queue.size() < CALM_TAIL) begin
            rsp_bus.ready <= 1'b1;
         end else if (stall > 0) begin
            stall         <= stall - 1;
            rsp_bus.ready <= 1'b0;
         end else if ($urandom_range(0, 5) == 0) begin
            stall         <= $urandom_range(0, 4);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int total;
      int kind;
      reset          = 1'b1;
      cycles         = 0;
      errors         = 0;
      req_bus.valid  = 1'b0;
      req_bus.symbol = '0;
      req_bus.last   = 1'b0;
      rsp_bus.ready  = 1'b0;

      // directed strings
      queue_string(1, 1, 8'h00);
      queue_string(1, 1, 8'hff);
      queue_pair(8'h5a, 8'h5a, 1'b1);
      queue_pair(8'h00, 8'hff, 1'b1);
      queue_pair(8'h61, 8'h62, 1'b0);
      symbol_queue.push_back('{symbol: 8'h61, last: 1'b1});
      queue_pair(8'haa, 8'h55, 1'b0);
      queue_pair(8'h55, 8'haa, 1'b1);
      queue_string(4, 1, 8'h80);

      // full length with one symbol gives the largest count
      queue_string(PCS_MAX_LEN, 1, symbol_type'($urandom));
      // closing beat dropped as the first extra symbol
      queue_string(PCS_MAX_LEN + 1, 4, symbol_type'($urandom));

      total = symbol_queue.size();
      while (total < 400) begin
         kind = $urandom_range(0, 19);
         if (kind == 0)
            queue_string(PCS_MAX_LEN, 1, symbol_type'($urandom));
         else if (kind == 1)
            queue_string($urandom_range(PCS_MAX_LEN + 1, PCS_MAX_LEN + 8), 256, 8'h00);
         else if (kind <= 3)
            queue_string($urandom_range(9, PCS_MAX_LEN), $urandom_range(1, 3) * 2, symbol_type'($urandom));
         else if (kind <= 11)
            queue_string($urandom_range(1, 8), $urandom_range(1, 4), symbol_type'($urandom));
         else
            queue_string($urandom_range(1, 8), 256, 8'h00);
         total = symbol_queue.size();
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (symbol_queue.size() != 0 || req_bus.valid || count_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (errors == 0 && count_queue.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/pcs_pkg.sv
rtl/core/pcs_req_if.sv
rtl/core/pcs_rsp_if.sv
rtl/core/pcs_text.sv
rtl/core/pcs_diag.sv
rtl/core/pcs_alu.sv
rtl/core/palindromic_subsequence_counter_core.sv
tb/palindromic_subsequence_counter_core_tb.sv
